[hdl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Sizes of the store, field widths, command codes, controller states and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // store geometry and field widths
    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 4;
    localparam int RANK_W     = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int EFF_W      = (CAP_BITS > CNT_W) ? CAP_BITS : CNT_W;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;   // word index of the capacity register
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(8);

    // request operations
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;   // capture the incoming request
        logic lookup;     // register match, victim and read data
        logic commit;     // update the store and load the result
    } t_dp_cmd;

endpackage

[hdl/lkvc_ctrl.sv]
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer for the LRU key-value cache
// Takes one request at a time through lookup and commit, and owns the valid
// flag of the result register so a finished result can wait for the sink.
// ----------------------------------------------------------------------------
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_dp_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_xfer;
    logic   out_free;

    // state and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_xfer  = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_dp_cmd         = '0;
        o_dp_cmd.load_req = in_xfer;
        n_out_valid      = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_dp_cmd.lookup = 1'b1;
                n_state         = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_dp_cmd.commit = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/lkvc_dp.sv]
// ----------------------------------------------------------------------------
// lkvc_dp: entry store and lookup datapath for the LRU key-value cache
// Holds keys, values, valid flags and recency ranks. Lookup matches all
// entries at once and picks the victim; commit applies the update.
// ----------------------------------------------------------------------------
module lkvc_dp
    import lkvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_dp_cmd,
    input  logic [CAP_BITS-1:0]   i_capacity,
    input  logic                  i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key
);

    // entry store
    logic [KEY_BITS-1:0]   r_key  [ENTRIES];
    logic [VALUE_BITS-1:0] r_val  [ENTRIES];
    logic [RANK_W-1:0]     r_rank [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [CNT_W-1:0]      r_count;

    // captured request
    logic                  r_req_cmd;
    logic [KEY_BITS-1:0]   r_req_key;
    logic [VALUE_BITS-1:0] r_req_value;

    // lookup results
    logic                  r_lk_hit;
    logic [RANK_W-1:0]     r_lk_slot;
    logic [RANK_W-1:0]     r_lk_rank;
    logic [VALUE_BITS-1:0] r_lk_rdval;
    logic                  r_lk_evict;
    logic [RANK_W-1:0]     r_lk_evslot;
    logic [KEY_BITS-1:0]   r_lk_evkey;

    // result register
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_read_value;
    logic                  r_evicted;
    logic [KEY_BITS-1:0]   r_evicted_key;

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    lru;
    logic                  hit_any;
    logic [RANK_W-1:0]     hit_slot;
    logic [RANK_W-1:0]     lru_slot;
    logic [EFF_W-1:0]      eff_cap;
    logic                  evict;
    logic [ENTRIES-1:0]    keep;
    logic [RANK_W-1:0]     free_slot;

    // parallel match and least-recent search; ranks of valid entries are
    // a permutation of 0..count-1, so the victim holds rank count-1
    always_comb begin
        hit_slot = '0;
        lru_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == r_req_key);
            lru[i]   = r_valid[i] && (CNT_W'(r_rank[i]) == (r_count - CNT_W'(1)));
            if (match[i]) begin
                hit_slot = hit_slot | RANK_W'(i);
            end
            if (lru[i]) begin
                lru_slot = lru_slot | RANK_W'(i);
            end
        end
        hit_any = |match;
    end

    // capacity clamped to 1..ENTRIES
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = EFF_W'(1);
        end else if (EFF_W'(i_capacity) > EFF_W'(ENTRIES)) begin
            eff_cap = EFF_W'(ENTRIES);
        end else begin
            eff_cap = EFF_W'(i_capacity);
        end
    end

    assign evict = (r_req_cmd == CMD_PUT) && !hit_any && (r_count != '0)
                && (EFF_W'(r_count) >= eff_cap);

    // entries kept on insert, and the lowest free slot among the rest
    always_comb begin
        keep = r_valid;
        if (r_lk_evict) begin
            keep[r_lk_evslot] = 1'b0;
        end
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!keep[i]) begin
                free_slot = RANK_W'(i);
            end
        end
    end

    // request capture and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_req) begin
            r_req_cmd   <= i_cmd;
            r_req_key   <= i_key;
            r_req_value <= i_value;
        end
        if (i_dp_cmd.lookup) begin
            r_lk_hit    <= hit_any;
            r_lk_slot   <= hit_slot;
            r_lk_rank   <= r_rank[hit_slot];
            r_lk_rdval  <= (hit_any && r_req_cmd == CMD_GET) ? r_val[hit_slot] : '0;
            r_lk_evict  <= evict;
            r_lk_evslot <= lru_slot;
            r_lk_evkey  <= evict ? r_key[lru_slot] : '0;
        end
        if (i_dp_cmd.commit) begin
            r_hit         <= r_lk_hit;
            r_read_value  <= r_lk_rdval;
            r_evicted     <= r_lk_evict;
            r_evicted_key <= r_lk_evkey;
        end
    end

    // key and value store
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit && r_req_cmd == CMD_PUT) begin
            if (r_lk_hit) begin
                r_val[r_lk_slot] <= r_req_value;
            end else begin
                r_key[free_slot] <= r_req_key;
                r_val[free_slot] <= r_req_value;
            end
        end
    end

    // valid flags, recency ranks and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_dp_cmd.commit) begin
            if (r_lk_hit) begin
                // promote: more recent entries move down one place
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] < r_lk_rank)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
                r_rank[r_lk_slot] <= '0;
            end else if (r_req_cmd == CMD_PUT) begin
                // insert: all survivors age, victim cleared, new entry on top
                for (int i = 0; i < ENTRIES; i++) begin
                    if (RANK_W'(i) == free_slot) begin
                        r_rank[i] <= '0;
                    end else if (keep[i]) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end else if (r_lk_evict && (RANK_W'(i) == r_lk_evslot)) begin
                        r_rank[i] <= '0;
                    end
                end
                r_valid <= keep | (ENTRIES'(1) << free_slot);
                if (!r_lk_evict) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

    // fill count tracks the valid flags
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("fill count disagrees with valid flags");

    // the store never overfills
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= ENTRIES)
        else $error("fill count above store size");

    // a committed put always leaves at least one entry
    a_put_leaves_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.commit && r_req_cmd == CMD_PUT) |=> (r_count != '0))
        else $error("store empty after put");

    // a victim is only chosen on a miss
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.commit |-> !(r_lk_evict && r_lk_hit))
        else $error("eviction on a hit");

endmodule

[hdl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
//
//   channel   direction  handshake                    payload
//   request   in         i_in_valid / o_in_stall      i_cmd, i_key, i_value
//   result    out        o_out_valid / i_out_stall    o_hit, o_read_value,
//                                                     o_evicted, o_evicted_key
//   config    in         APB (psel, penable, pwrite)  paddr, pwdata, prdata
//
// Each request goes through capture, parallel lookup over all entries, and
// commit of the store update into the result register. The next request is
// taken in the cycle after commit, while the result may still wait.
// A stalled result holds the commit step until the result register frees.
// Reset clears all valid flags, ranks and the fill count at once; capacity
// resets to the full store.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    // result
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_BITS-1:0] r_capacity;
    t_dp_cmd             dp_cmd;
    logic                cap_sel;

    // capacity register
    assign cap_sel = (paddr[APB_ADDR_W-1] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    assign prdata = cap_sel ? APB_DATA_W'(r_capacity) : '0;
    assign pready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd)
    );

    lkvc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .i_capacity    (r_capacity),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

[sim/lru_key_value_cache_checker.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker: result checker for the LRU key-value cache
// Watches the request, result and configuration traffic, keeps its own copy
// of the store with its recency order, predicts the result of every accepted
// request and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker
    import lkvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_hit,
    input  logic [VALUE_BITS-1:0] i_read_value,
    input  logic                  i_evicted,
    input  logic [KEY_BITS-1:0]   i_evicted_key,
    // configuration writes
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    // status to the testbench top
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } t_lookup_result;

    // shadow copy of the store
    logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
    logic [VALUE_BITS-1:0] slot_value [ENTRIES];
    logic                  slot_used  [ENTRIES];
    int                    slot_age   [ENTRIES];   // 0 = most recent
    int                    fill_count;
    logic [CAP_BITS-1:0]   capacity_reg;

    t_lookup_result        pending_lookups[$];

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        o_mismatches++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Move a slot to the front; entries that were more recent age by one.
    task automatic make_most_recent(input int slot);
        int age;
        age = slot_age[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_age[i] < age)
                slot_age[i]++;
        slot_age[slot] = 0;
    endtask

    // Apply one request to the shadow store and work out its result.
    task automatic lookup_and_update(input logic cmd, input logic [KEY_BITS-1:0] key,
                                     input logic [VALUE_BITS-1:0] value,
                                     output t_lookup_result res);
        int slot;
        int oldest;
        int free_slot;
        int eff_cap;
        res  = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && slot_used[i] && slot_key[i] == key)
                slot = i;

        // zero behaves as one, anything above the store size saturates
        eff_cap = int'(capacity_reg);
        if (eff_cap == 0)
            eff_cap = 1;
        if (eff_cap > ENTRIES)
            eff_cap = ENTRIES;

        if (cmd == CMD_GET) begin
            if (slot >= 0) begin
                res.hit        = 1'b1;
                res.read_value = slot_value[slot];
                make_most_recent(slot);
            end
        end else if (slot >= 0) begin
            res.hit          = 1'b1;
            slot_value[slot] = value;
            make_most_recent(slot);
        end else begin
            // full (or over a lowered capacity): drop exactly one oldest entry
            if (fill_count >= eff_cap && fill_count > 0) begin
                oldest = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                        oldest = i;
                if (oldest >= 0) begin
                    res.evicted       = 1'b1;
                    res.evicted_key   = slot_key[oldest];
                    slot_used[oldest] = 1'b0;
                    slot_age[oldest]  = 0;
                    fill_count--;
                end
            end
            // new key goes to the lowest free slot
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            if (free_slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i])
                        slot_age[i]++;
                slot_used[free_slot]  = 1'b1;
                slot_key[free_slot]   = key;
                slot_value[free_slot] = value;
                slot_age[free_slot]   = 0;
                fill_count++;
            end
        end
    endtask

    // sample all channels on the rising edge
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_used[i]  = 1'b0;
                slot_age[i]   = 0;
            end
            fill_count   = 0;
            capacity_reg = CAPACITY_RESET;
            o_mismatches = 0;
            pending_lookups.delete();
        end else begin
            // register write; other word indexes are ignored
            if (i_psel && i_penable && i_pwrite && i_pready && (i_paddr >> 2) == REG_CAPACITY)
                capacity_reg = i_pwdata[CAP_BITS-1:0];

            // request transfer
            if (i_in_valid && !i_in_stall) begin
                lookup_and_update(i_cmd, i_key, i_value, want);
                pending_lookups.push_back(want);
            end

            // result transfer
            if (i_out_valid && !i_out_stall) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = pending_lookups.pop_front();
                    if (i_hit !== want.hit)
                        report_mismatch($sformatf("hit got %b want %b", i_hit, want.hit));
                    if (i_read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %h want %h",
                                                  i_read_value, want.read_value));
                    if (i_evicted !== want.evicted)
                        report_mismatch($sformatf("evicted got %b want %b",
                                                  i_evicted, want.evicted));
                    if (i_evicted_key !== want.evicted_key)
                        report_mismatch($sformatf("evicted_key got %h want %h",
                                                  i_evicted_key, want.evicted_key));
                end
            end
        end
        o_outstanding = pending_lookups.size();
    end

endmodule

[sim/lru_key_value_cache_tb.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: testbench top for the LRU key-value cache
// Drives directed and random get/put traffic over several capacity settings,
// with random idling on both channels, a long result hold-off and a full
// drain; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    import lkvc_pkg::*;

    localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = APB_ADDR_W'(4 * REG_CAPACITY);
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR   = APB_ADDR_W'(4 * (REG_CAPACITY + 1));
    localparam int POOL_SIZE    = 12;
    localparam int BLOCKS       = 11;
    localparam int BLOCK_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  req_taken = 1'b0;
    logic                  hold_request = 1'b0;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    mismatches;
    int                    outstanding;
    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];

    always #2 clk = ~clk;

    lru_key_value_cache uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_key         (key),
        .i_value       (value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_hit         (hit),
        .o_read_value  (read_value),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lru_key_value_cache_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_key         (key),
        .i_value       (value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_hit         (hit),
        .i_read_value  (read_value),
        .i_evicted     (evicted),
        .i_evicted_key (evicted_key),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // request transfer seen at the rising edge, read by the driver at the falling one
    always @(posedge clk) begin
        req_taken <= in_valid && !in_stall;
    end

    // result side: random stalls, or a long counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // offer one request, with random gaps ahead of it, and hold it until taken
    task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k,
                                input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = op;
        key      = k;
        value    = v;
        do
            @(negedge clk);
        while (!req_taken);
        in_valid = 1'b0;
    endtask

    // register write: setup cycle then access cycle
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // capacity write once the block has gone quiet; upper data bits are junk
    task automatic set_capacity(input int cap);
        wait_drained();
        repeat (4) @(negedge clk);
        write_register(CAPACITY_ADDR, ($urandom & ~32'hF) | APB_DATA_W'(cap));
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_BITS'($urandom_range(0, 65535));
    endtask

    // mostly keys from a small pool so hits and evictions are common
    task automatic random_request();
        logic [KEY_BITS-1:0] k;
        if ($urandom_range(0, 9) == 0)
            k = KEY_BITS'($urandom_range(0, 65535));
        else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, $urandom);
    endtask

    // overall time limit
    initial begin
        #2000000;
        $display("[lru_key_value_cache] ERROR");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int caps [BLOCKS];
        caps = '{8, 1, 4, 0, 15, 2, 8, 5, 3, 7, 6};

        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_GET;
        key      = '0;
        value    = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 13;
        rx_idle_pct = 61;

        // directed: empty store, key and value extremes, update, fill and evict
        send_request(CMD_GET, 16'h0000, 32'hFFFF_FFFF);
        send_request(CMD_PUT, 16'h0000, 32'h0000_0000);
        send_request(CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 16'hFFFF, 32'h0000_0000);
        send_request(CMD_GET, 16'h0000, 32'h1234_5678);
        send_request(CMD_PUT, 16'h0000, 32'hA5A5_A5A5);
        for (int i = 1; i <= 6; i++)
            send_request(CMD_PUT, KEY_BITS'(i * 16'h1111), $urandom);
        send_request(CMD_GET, 16'hFFFF, 32'h0);
        send_request(CMD_PUT, 16'h8000, 32'h8000_0001);
        send_request(CMD_GET, 16'h0000, 32'h0);

        // capacity dropped below the fill level: one eviction per new key
        set_capacity(1);
        send_request(CMD_PUT, 16'h0101, 32'h0101_0101);
        send_request(CMD_PUT, 16'h0202, 32'h0202_0202);
        send_request(CMD_GET, 16'hFFFF, 32'h0);

        // zero capacity acts as one
        set_capacity(0);
        send_request(CMD_PUT, 16'h0303, 32'h0303_0303);
        send_request(CMD_PUT, 16'h0404, 32'h0404_0404);
        send_request(CMD_GET, 16'h0404, 32'h0);

        // over-range capacity saturates; a write to an unused index is ignored
        set_capacity(15);
        write_register(UNUSED_ADDR, 32'h0000_0001);
        send_request(CMD_PUT, 16'h0505, 32'h0505_0505);
        send_request(CMD_PUT, 16'h0606, 32'h0606_0606);
        send_request(CMD_GET, 16'h0505, 32'h0);

        // random blocks, each at its own capacity
        for (int b = 0; b < BLOCKS; b++) begin
            set_capacity(caps[b]);
            if (b < 4) begin
                tx_idle_pct = 13;
                rx_idle_pct = 61;
            end else if (b < 8) begin
                tx_idle_pct = 61;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            refill_pool();
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if (n == BLOCK_ITEMS / 2) begin
                    refill_pool();
                    if (b == 2)
                        hold_request = 1'b1;
                    if (b == 5)
                        wait_drained();
                end
                random_request();
            end
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[lru_key_value_cache] OK");
        end else begin
            $display("[lru_key_value_cache] ERROR");
        end
        $finish;
    end

endmodule
